FILE: hdl/tfr_pkg.sv
// Shared constants, codes and controller/datapath interface types of the frame receiver.
`timescale 1ns / 1ps

package tfr_pkg;

  // Incoming frame header and field limits
  localparam logic [7:0] SYNC_BYTE_1 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE_2 = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT  = 8'hF1;

  // Function codes
  localparam logic [7:0] FUNC_READ      = 8'h02;
  localparam logic [7:0] READ_ARG       = 8'h01;
  localparam logic [7:0] FUNC_GAIN_RATE = 8'h10;
  localparam logic [7:0] FUNC_GAIN_ATT  = 8'h11;
  localparam logic [7:0] FUNC_ACK_LO    = 8'h12;
  localparam logic [7:0] FUNC_ACK_HI    = 8'h15;

  // Acknowledge frame
  localparam logic [7:0] ACK_SYNC = 8'hAA;
  localparam logic [7:0] ACK_ID   = 8'hEF;
  localparam logic [7:0] ACK_LEN  = 8'h02;
  localparam logic [7:0] ACK_PREFIX_SUM = 8'(ACK_SYNC + ACK_SYNC + ACK_ID + ACK_LEN);
  localparam logic [3:0] ACK_IDX_SYNC2 = 4'd1;
  localparam logic [3:0] ACK_IDX_ID    = 4'd2;
  localparam logic [3:0] ACK_IDX_LEN   = 4'd3;
  localparam logic [3:0] ACK_IDX_FUNC  = 4'd4;
  localparam logic [3:0] ACK_IDX_SUM   = 4'd5;
  localparam logic [3:0] ACK_IDX_CHK   = 4'd6;

  // Payload store: 18 bytes held as even and odd banks of 9 rows
  localparam int unsigned STORE_DEPTH = 18;
  localparam int unsigned STORE_ROWS  = 9;
  localparam int unsigned ROW_W       = 4;

  // Result kinds
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_GAIN = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  // Emission modes
  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_GAIN = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;

  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic func_load;
    logic len_load;
    logic data_step;
    logic store_byte;
    logic start_emit;
    logic emit_en;
  } tfr_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic func_ok;
    logic len_ok;
    logic rem_nonzero;
    logic rem_one;
    logic sum_match;
    logic has_results;
    logic emit_take;
    logic emit_last;
  } tfr_status_t;

endpackage

FILE: hdl/telemetry_frame_receiver_unit.sv
// Top level of the telemetry frame receiver: parser controller plus datapath.
`timescale 1ns / 1ps

// Byte-serial receiver for sum-checked command frames.
// Input channel: one received byte per item on rx_byte_i (in_valid_i / in_ready_o).
// Output channel: one result per item (out_valid_o / out_ready_i) carrying kind,
// gain group, gain index, gain value, acknowledge byte and a last flag that marks
// the final result of a frame.
// While a frame is being parsed a byte is taken every cycle. A checksum byte that
// closes a valid frame with results puts the block into emission: the emit phase
// loads the first result once the output register is free; results then follow
// one per cycle while they are taken: one for a read request, seven for an ack
// frame, or GAIN_COUNT gains and seven ack bytes (sixteen by default). The shared
// output register sets that rate; no byte is taken during emission.
// Once the last result is loaded, parsing resumes while it waits to be taken.
// A stalled receiver simply holds the output register and pauses emission.
// Reset returns the parser to header hunting, clears the running sum, counts and
// function code, zeroes the 18-byte payload store and empties the output register.
module telemetry_frame_receiver_unit #(
  parameter int unsigned LENGTH_LIMIT = 50,
  parameter int unsigned GAIN_COUNT   = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic               gain_group_o,
  output logic [3:0]         gain_index_o,
  output logic signed [15:0] gain_value_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_o
);
  import tfr_pkg::*;

  tfr_cmd_t    cmd;
  tfr_status_t status;

  tfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfr_datapath #(
    .LENGTH_LIMIT (LENGTH_LIMIT),
    .GAIN_COUNT   (GAIN_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .gain_group_o (gain_group_o),
    .gain_index_o (gain_index_o),
    .gain_value_o (gain_value_o),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o)
  );

endmodule

FILE: hdl/tfr_ctrl.sv
// Frame parsing and result emission state machine of the frame receiver.
`timescale 1ns / 1ps

module tfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tfr_pkg::tfr_status_t status_i,
  output tfr_pkg::tfr_cmd_t    cmd_o
);
  import tfr_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HEAD1 = 3'd1;
  localparam logic [2:0] PH_HEAD2 = 3'd2;
  localparam logic [2:0] PH_FUNC  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_EMIT  = 3'd6;

  logic [2:0] phase_d, phase_q;
  logic       in_fire;

  assign in_ready_o = (phase_q != PH_EMIT);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_fire && status_i.is_sync1) begin
          phase_d        = PH_HEAD1;
          cmd_o.sum_load = 1'b1;
        end
      end
      PH_HEAD1: begin
        if (in_fire) begin
          if (status_i.is_sync2) begin
            phase_d       = PH_HEAD2;
            cmd_o.sum_add = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_HEAD2: begin
        if (in_fire) begin
          if (status_i.func_ok) begin
            phase_d         = PH_FUNC;
            cmd_o.sum_add   = 1'b1;
            cmd_o.func_load = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_FUNC: begin
        if (in_fire) begin
          if (status_i.len_ok) begin
            phase_d        = PH_DATA;
            cmd_o.sum_add  = 1'b1;
            cmd_o.len_load = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          // A zero length frame ends here: the next byte is swallowed.
          if (status_i.rem_nonzero) begin
            cmd_o.sum_add    = 1'b1;
            cmd_o.data_step  = 1'b1;
            cmd_o.store_byte = 1'b1;
            phase_d          = status_i.rem_one ? PH_CHECK : PH_DATA;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_CHECK: begin
        if (in_fire) begin
          cmd_o.store_byte = 1'b1;
          if (status_i.sum_match && status_i.has_results) begin
            phase_d          = PH_EMIT;
            cmd_o.start_emit = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (status_i.emit_take && status_i.emit_last) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

FILE: hdl/tfr_datapath.sv
// Running sum, payload store, result sequencing and output register of the frame receiver.
`timescale 1ns / 1ps

module tfr_datapath #(
  parameter int unsigned LENGTH_LIMIT = 50,
  parameter int unsigned GAIN_COUNT   = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  tfr_pkg::tfr_cmd_t    cmd_i,
  output tfr_pkg::tfr_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic                 gain_group_o,
  output logic [3:0]           gain_index_o,
  output logic signed [15:0]   gain_value_o,
  output logic [7:0]           tx_byte_o,
  output logic                 last_o
);
  import tfr_pkg::*;

  logic [7:0] sum_q;
  logic [7:0] func_q;
  logic [5:0] rem_q;
  logic [5:0] count_q;
  logic [7:0] even_q [STORE_ROWS];
  logic [7:0] odd_q  [STORE_ROWS];
  logic [1:0] mode_q;
  logic [3:0] idx_q;
  logic       out_valid_q;

  logic [1:0]        start_mode;
  logic              is_read, is_gain, is_ack;
  logic              emit_load;
  logic [7:0]        ack_chk;
  logic [1:0]        res_kind;
  logic              res_group;
  logic [3:0]        res_index;
  logic signed [15:0] res_value;
  logic [7:0]        res_tx;
  logic              res_last;

  assign is_read = (func_q == FUNC_READ) && (even_q[0] == READ_ARG);
  assign is_gain = (func_q == FUNC_GAIN_RATE) || (func_q == FUNC_GAIN_ATT);
  assign is_ack  = (func_q >= FUNC_ACK_LO) && (func_q <= FUNC_ACK_HI);

  always_comb begin
    if (is_gain) begin
      start_mode = MODE_GAIN;
    end else if (is_ack) begin
      start_mode = MODE_ACK;
    end else begin
      start_mode = MODE_READ;
    end
  end

  assign emit_load = cmd_i.emit_en && (!out_valid_q || out_ready_i);

  always_comb begin
    status_o             = '0;
    status_o.is_sync1    = (rx_byte_i == SYNC_BYTE_1);
    status_o.is_sync2    = (rx_byte_i == SYNC_BYTE_2);
    status_o.func_ok     = (rx_byte_i < FUNC_LIMIT);
    status_o.len_ok      = ({1'b0, rx_byte_i} < 9'(LENGTH_LIMIT));
    status_o.rem_nonzero = (rem_q != 6'd0);
    status_o.rem_one     = (rem_q == 6'd1);
    status_o.sum_match   = (rx_byte_i == sum_q);
    status_o.has_results = is_read || is_gain || is_ack;
    status_o.emit_take   = !out_valid_q || out_ready_i;
    status_o.emit_last   = (mode_q == MODE_READ) ||
                           ((mode_q == MODE_ACK) && (idx_q == ACK_IDX_CHK));
  end

  assign ack_chk = 8'(ACK_PREFIX_SUM + func_q + sum_q);

  // Result selected by the emission mode and position.
  always_comb begin
    res_kind  = KIND_READ;
    res_group = 1'b0;
    res_index = 4'd0;
    res_value = '0;
    res_tx    = 8'd0;
    res_last  = 1'b0;
    case (mode_q)
      MODE_GAIN: begin
        res_kind  = KIND_GAIN;
        res_group = func_q[0];
        res_index = idx_q;
        res_value = {even_q[idx_q], odd_q[idx_q]};
      end
      MODE_ACK: begin
        res_kind = KIND_ACK;
        if (idx_q == ACK_IDX_CHK) begin
          res_tx   = ack_chk;
          res_last = 1'b1;
        end else if (idx_q == ACK_IDX_SUM) begin
          res_tx = sum_q;
        end else if (idx_q == ACK_IDX_FUNC) begin
          res_tx = func_q;
        end else if (idx_q == ACK_IDX_LEN) begin
          res_tx = ACK_LEN;
        end else if (idx_q == ACK_IDX_ID) begin
          res_tx = ACK_ID;
        end else begin
          res_tx = ACK_SYNC;
        end
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= 8'd0;
      func_q      <= 8'd0;
      rem_q       <= 6'd0;
      count_q     <= 6'd0;
      mode_q      <= MODE_READ;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STORE_ROWS; i++) begin
        even_q[i] <= 8'd0;
        odd_q[i]  <= 8'd0;
      end
    end else begin
      if (cmd_i.sum_load) begin
        sum_q <= rx_byte_i;
      end else if (cmd_i.sum_add) begin
        sum_q <= 8'(sum_q + rx_byte_i);
      end
      if (cmd_i.func_load) begin
        func_q <= rx_byte_i;
      end
      if (cmd_i.len_load) begin
        rem_q   <= rx_byte_i[5:0];
        count_q <= 6'd0;
      end else if (cmd_i.data_step) begin
        rem_q   <= rem_q - 6'd1;
        count_q <= count_q + 6'd1;
      end
      // Bytes past the store are summed but not kept.
      if (cmd_i.store_byte && (count_q < 6'(STORE_DEPTH))) begin
        if (count_q[0]) begin
          odd_q[count_q[ROW_W:1]] <= rx_byte_i;
        end else begin
          even_q[count_q[ROW_W:1]] <= rx_byte_i;
        end
      end
      if (cmd_i.start_emit) begin
        mode_q <= start_mode;
        idx_q  <= 4'd0;
      end else if (emit_load) begin
        if ((mode_q == MODE_GAIN) && (idx_q == 4'(GAIN_COUNT - 1))) begin
          mode_q <= MODE_ACK;
          idx_q  <= 4'd0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      kind_o       <= res_kind;
      gain_group_o <= res_group;
      gain_index_o <= res_index;
      gain_value_o <= res_value;
      tx_byte_o    <= res_tx;
      last_o       <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
